// ===== rtl/sbsm_pkg.sv =====
package sbsm_pkg;

  localparam int CART_RAM_BYTES  = 8192;
  localparam int NAMETABLE_BYTES = 2048;

  localparam int OFFSET_W = 18;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 3;

  localparam logic [OFFSET_W-1:0] CART_RAM_MASK = OFFSET_W'(CART_RAM_BYTES - 1);
  localparam logic [OFFSET_W-1:0] NAMETABLE_MASK = OFFSET_W'(NAMETABLE_BYTES - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_SIZE_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_SIZE_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_IS_RAM    = 2'd2;

  typedef enum logic [1:0] {
    OP_CPU_RD = 2'd0,
    OP_CPU_WR = 2'd1,
    OP_PPU_RD = 2'd2,
    OP_PPU_WR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    TGT_IGNORED   = 3'd0,
    TGT_INVALID   = 3'd1,
    TGT_OPENBUS   = 3'd2,
    TGT_PRGROM    = 3'd3,
    TGT_PRGRAM    = 3'd4,
    TGT_CHRROM    = 3'd5,
    TGT_CHRRAM    = 3'd6,
    TGT_NAMETABLE = 3'd7
  } target_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_t;

  typedef struct packed {
    target_t             target;
    logic [OFFSET_W-1:0] mem_offset;
    logic                mem_write;
    logic [7:0]          mem_data;
  } out_t;

endpackage

// ===== rtl/serial_bank_switch_mapper.sv =====
// Serial bank-switch mapper: bus address translation.
//
// Input channel (in_valid / in_stall / in_data): one CPU or PPU bus access
// per transfer. Output channel (out_valid / out_stall / out_data): exactly
// one translated access per input transfer, in order: the target memory,
// the byte offset into it, and the write strobe and data.
// CPU writes at 0x8000 and above feed the 5-bit serial load register and
// bank registers; they come out as target "ignored".
//
// An accepted access is registered into the result register, or into the skid
// register while a result waits. Throughput is one access per cycle while
// in_stall is low; the whole translation is one short combinational pass
// into the output stage. A two-entry output stage (result register plus
// skid register) lets one more access in while a result waits; in_stall
// rises only when both entries hold results and is a registered signal.
//
// Reset (rst_n low, synchronous) empties the output stage, puts the bank
// state at its power-on values and the size registers at 16K*16 PRG,
// 8K CHR RAM. The user is to write size registers through the cfg_ port only while idle; the block does not enforce it.
module serial_bank_switch_mapper (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sbsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbsm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  sbsm_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output sbsm_pkg::out_t                   out_data
);

  // Configuration
  logic [2:0] prg_size_log2_r;
  logic [2:0] chr_size_log2_r;
  logic       chr_is_ram_r;

  // Mapper state
  logic [4:0] serial_shift_r, serial_shift_nxt;
  logic [1:0] mirror_mode_r, mirror_mode_nxt;
  logic [1:0] prg_mode_r, prg_mode_nxt;
  logic       chr_mode_4k_r, chr_mode_4k_nxt;
  logic [4:0] chr_bank_low_r, chr_bank_low_nxt;
  logic [4:0] chr_bank_high_r, chr_bank_high_nxt;
  logic [3:0] prg_bank_r, prg_bank_nxt;

  // Output stage
  logic           out_valid_r;
  sbsm_pkg::out_t out_data_r;
  logic           skid_valid_r;
  sbsm_pkg::out_t skid_data_r;

  sbsm_pkg::out_t res;
  logic           accept;
  logic           out_free;

  logic [2:0]  prg_lg;
  logic [2:0]  chr_lg;
  logic [17:0] prg_mask;
  logic [16:0] chr_mask;
  logic [3:0]  prg_last;
  logic [17:0] prg_off;
  logic [16:0] chr_off;
  logic [17:0] nt_off;
  logic [15:0] ram_rel;
  logic [13:0] ppu_addr;
  logic [4:0]  load_val;
  logic [4:0]  chr_load_val;
  logic        small_chr;
  logic        shift_full;
  logic        is_wr;

  assign accept   = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Size-derived masks
  always_comb begin
    prg_lg   = (prg_size_log2_r > 3'd4) ? 3'd4 : prg_size_log2_r;
    chr_lg   = (chr_size_log2_r > 3'd5) ? 3'd5 : chr_size_log2_r;
    prg_mask = 18'((19'h04000 << prg_lg) - 19'd1);
    chr_mask = 17'((18'h01000 << chr_lg) - 18'd1);
    prg_last = 4'((5'd1 << prg_lg) - 5'd1);
  end

  // Bank offsets
  always_comb begin
    logic upper;
    upper = in_data.address[14];
    ppu_addr = in_data.address[13:0];

    case (prg_mode_r)
      2'd0, 2'd1: prg_off = {prg_bank_r[3:1], in_data.address[14:0]};
      2'd2:       prg_off = {(upper ? prg_bank_r : 4'd0), in_data.address[13:0]};
      default:    prg_off = {(upper ? prg_last : prg_bank_r), in_data.address[13:0]};
    endcase
    prg_off = prg_off & prg_mask;

    if (chr_mode_4k_r) begin
      chr_off = {(ppu_addr[12] ? chr_bank_high_r : chr_bank_low_r), ppu_addr[11:0]};
    end else begin
      chr_off = {chr_bank_low_r[4:1], ppu_addr[12:0]};
    end

    // Subtracting 0x1000 for the 0x3000 mirror leaves bits 11..0 as they are
    case (mirror_mode_r)
      2'd0:    nt_off = {8'd0, ppu_addr[9:0]};
      2'd1:    nt_off = {8'd1, ppu_addr[9:0]};
      2'd2:    nt_off = {7'd0, ppu_addr[10:0]};
      default: nt_off = {7'd0, ppu_addr[11], ppu_addr[9:0]};
    endcase
    nt_off = nt_off & sbsm_pkg::NAMETABLE_MASK;

    ram_rel = in_data.address - 16'h6000;
  end

  // Translation
  always_comb begin
    res.target     = sbsm_pkg::TGT_IGNORED;
    res.mem_offset = '0;
    res.mem_write  = 1'b0;
    is_wr          = (in_data.op == sbsm_pkg::OP_PPU_WR);

    case (in_data.op)
      sbsm_pkg::OP_CPU_RD: begin
        if (in_data.address < 16'h4020) begin
          res.target = sbsm_pkg::TGT_INVALID;
        end else if (in_data.address < 16'h6000) begin
          res.target = sbsm_pkg::TGT_OPENBUS;
        end else if (in_data.address < 16'h8000) begin
          res.target     = sbsm_pkg::TGT_PRGRAM;
          res.mem_offset = {2'd0, ram_rel} & sbsm_pkg::CART_RAM_MASK;
        end else begin
          res.target     = sbsm_pkg::TGT_PRGROM;
          res.mem_offset = prg_off;
        end
      end
      sbsm_pkg::OP_CPU_WR: begin
        if (in_data.address >= 16'h6000 && in_data.address < 16'h8000) begin
          res.target     = sbsm_pkg::TGT_PRGRAM;
          res.mem_offset = {2'd0, ram_rel} & sbsm_pkg::CART_RAM_MASK;
          res.mem_write  = 1'b1;
        end
      end
      sbsm_pkg::OP_PPU_RD, sbsm_pkg::OP_PPU_WR: begin
        if (ppu_addr < 14'h2000) begin
          if (chr_is_ram_r) begin
            res.target     = sbsm_pkg::TGT_CHRRAM;
            res.mem_offset = {1'b0, chr_off & 17'h01FFF};
            res.mem_write  = is_wr;
          end else if (!is_wr) begin
            res.target     = sbsm_pkg::TGT_CHRROM;
            res.mem_offset = {1'b0, chr_off & chr_mask};
          end
        end else if (ppu_addr < 14'h3F00) begin
          res.target     = sbsm_pkg::TGT_NAMETABLE;
          res.mem_offset = nt_off;
          res.mem_write  = is_wr;
        end else if (!is_wr) begin
          res.target = sbsm_pkg::TGT_INVALID;
        end
      end
      default: begin
        res.target = sbsm_pkg::TGT_IGNORED;
      end
    endcase

    res.mem_data = res.mem_write ? in_data.write_data : 8'd0;
  end

  // Serial load register and bank registers
  always_comb begin
    serial_shift_nxt  = serial_shift_r;
    mirror_mode_nxt   = mirror_mode_r;
    prg_mode_nxt      = prg_mode_r;
    chr_mode_4k_nxt   = chr_mode_4k_r;
    chr_bank_low_nxt  = chr_bank_low_r;
    chr_bank_high_nxt = chr_bank_high_r;
    prg_bank_nxt      = prg_bank_r;

    small_chr    = chr_is_ram_r || (chr_size_log2_r <= 3'd1);
    shift_full   = serial_shift_r[0];
    load_val     = {in_data.write_data[0], serial_shift_r[4:1]};
    chr_load_val = small_chr ? {4'd0, load_val[0]} : load_val;

    if (in_data.op == sbsm_pkg::OP_CPU_WR && in_data.address[15]) begin
      if (in_data.write_data[7]) begin
        serial_shift_nxt = 5'h10;
        prg_mode_nxt     = 2'd3;
      end else if (shift_full) begin
        serial_shift_nxt = 5'h10;
        case (in_data.address[14:13])
          2'd0: begin
            mirror_mode_nxt = load_val[1:0];
            prg_mode_nxt    = load_val[3:2];
            chr_mode_4k_nxt = load_val[4];
          end
          2'd1:    chr_bank_low_nxt  = chr_load_val;
          2'd2:    chr_bank_high_nxt = chr_load_val;
          default: prg_bank_nxt      = load_val[3:0];
        endcase
      end else begin
        serial_shift_nxt = load_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_size_log2_r <= 3'd4;
      chr_size_log2_r <= 3'd1;
      chr_is_ram_r    <= 1'b1;
      serial_shift_r  <= 5'h10;
      mirror_mode_r   <= 2'd0;
      prg_mode_r      <= 2'd3;
      chr_mode_4k_r   <= 1'b0;
      chr_bank_low_r  <= 5'd0;
      chr_bank_high_r <= 5'd0;
      prg_bank_r      <= 4'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sbsm_pkg::CFG_PRG_SIZE_LOG2: prg_size_log2_r <= cfg_wdata;
          sbsm_pkg::CFG_CHR_SIZE_LOG2: chr_size_log2_r <= cfg_wdata;
          sbsm_pkg::CFG_CHR_IS_RAM:    chr_is_ram_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (accept) begin
        serial_shift_r  <= serial_shift_nxt;
        mirror_mode_r   <= mirror_mode_nxt;
        prg_mode_r      <= prg_mode_nxt;
        chr_mode_4k_r   <= chr_mode_4k_nxt;
        chr_bank_low_r  <= chr_bank_low_nxt;
        chr_bank_high_r <= chr_bank_high_nxt;
        prg_bank_r      <= prg_bank_nxt;
      end
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        // drain the skid entry first to keep order
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (accept) begin
        out_data_r <= res;
      end
    end else if (accept) begin
      skid_data_r <= res;
    end
  end

  // The skid entry is only ever filled behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty result register");

  // The marker bit keeps the serial register from ever reading zero
  a_shift_marker: assert property (@(posedge clk) disable iff (!rst_n)
    serial_shift_r != 5'd0)
    else $error("serial load register lost its marker bit");

  // Only writable memories get a write strobe
  a_write_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.mem_write) |->
      (out_data_r.target == sbsm_pkg::TGT_PRGRAM ||
       out_data_r.target == sbsm_pkg::TGT_CHRRAM ||
       out_data_r.target == sbsm_pkg::TGT_NAMETABLE))
    else $error("write strobe on a read-only target");

  // A reset byte always leaves PRG mode at fixed-last-bank
  a_reset_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.op == sbsm_pkg::OP_CPU_WR && in_data.address[15] &&
     in_data.write_data[7]) |=> (prg_mode_r == 2'd3 && serial_shift_r == 5'h10))
    else $error("reset byte did not restore serial state");

endmodule
